// ----- rtl/core/dpf_key_generation_assert.svh -----
// assertion macros shared by the rtl files
`ifndef DPF_KEY_GENERATION_ASSERT_SVH
`define DPF_KEY_GENERATION_ASSERT_SVH

// property that holds on every clock edge outside reset
`define DPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define DPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dpfkg_pkg.sv -----
`timescale 1ns / 1ps
package dpfkg_pkg;

  localparam int unsigned MaxLevels = 32;
  localparam int unsigned LevelW = 5;
  localparam int unsigned CfgW = 6;
  localparam logic [CfgW-1:0] DomainBitsReset = 6'd20;

  typedef struct packed {
    logic [31:0] location;
    logic [63:0] point_value;
    logic [63:0] party0_seed_hi;
    logic [63:0] party0_seed_lo;
    logic [63:0] party1_seed_hi;
    logic [63:0] party1_seed_lo;
  } dpf_in_t;

  typedef struct packed {
    logic [4:0]  level_index;
    logic [63:0] left_seed_corr_hi;
    logic [63:0] left_seed_corr_lo;
    logic [63:0] right_seed_corr_hi;
    logic [63:0] right_seed_corr_lo;
    logic        left_flag_corr;
    logic        right_flag_corr;
    logic [63:0] final_correction;
    logic        last_level;
  } dpf_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StHash0,
    StHash1,
    StEmit
  } dpf_state_e;

  // handshake between sequencer and hash core
  typedef struct packed {
    logic start;
    logic done;
  } sha_ctl_t;

  function automatic logic [31:0] k_round(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] ShaInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

// ----- rtl/core/dpfkg_sha_core.sv -----
`timescale 1ns / 1ps
// one sha-256 block per start, one round per cycle, 16-word schedule window
module dpfkg_sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [127:0]        msg_i,
  output logic                done_o,
  output logic [255:0]        digest_o
);
  import dpfkg_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [255:0] st_q, st_d;
  logic [255:0] dig_q, dig_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;

  always_comb begin
    {a, b, c, d, e, f, g, h} = st_q;
    t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & f) ^ (~e & g)) + k_round(rnd_q) + w_q[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & b) ^ (a & c) ^ (b & c));
    s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
  end

  // round sequencing
  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    done_d = 1'b0;
    st_d   = st_q;
    dig_d  = dig_q;
    for (int i = 0; i < 16; i++) w_d[i] = w_q[i];
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      rnd_d  = '0;
      st_d   = ShaInit;
      for (int i = 0; i < 4; i++) w_d[i] = msg_i[127-32*i -: 32];
      w_d[4] = 32'h80000000;
      for (int i = 5; i < 15; i++) w_d[i] = '0;
      w_d[15] = 32'h00000080;
    end else if (busy_q) begin
      st_d = {t1 + t2, a, b, c, d + t1, e, f, g};
      for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
      w_d[15] = wn;
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        for (int i = 0; i < 8; i++)
          dig_d[255-32*i -: 32] = ShaInit[255-32*i -: 32] + st_d[255-32*i -: 32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    dig_q <= dig_d;
    for (int i = 0; i < 16; i++) w_q[i] <= w_d[i];
  end

  assign done_o   = done_q;
  assign digest_o = dig_q;

`include "dpf_key_generation_assert.svh"
  `DPF_ASSERT_NEXT(a_done_ends, busy_q && rnd_q == 6'd63, done_q && !busy_q, "done missing")
  `DPF_ASSERT(a_done_idle, !(done_q && busy_q), "done while busy")
  `DPF_ASSERT_NEXT(a_rnd_step, busy_q && rnd_q != 6'd63, busy_q && rnd_q == $past(rnd_q) + 6'd1,
    "round skipped")
endmodule

// ----- rtl/core/dpf_key_generation.sv -----
`timescale 1ns / 1ps
// Generates one correction word per tree level for a two-party point-function
// key. Each input beat yields max(1, min(level count, 32)) output beats. The
// level count is the 6-bit register written through cfg_we_i (20 after reset).
// The user must write it only while the block is idle; the block itself does
// not enforce this. Each level runs two SHA-256 compressions on one shared
// round unit at one round per cycle, then holds the correction word until it
// is taken. The block takes no new input until the last word of the current
// item has been delivered.
module dpf_key_generation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dpfkg_pkg::dpf_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpfkg_pkg::dpf_out_t out_data_o
);
  import dpfkg_pkg::*;

  dpf_state_e st_q, st_d;
  logic [CfgW-1:0] dom_q;
  logic [5:0]   lev_q, lev_d;       // level count of this item
  logic [4:0]   idx_q, idx_d;
  logic [31:0]  loc_q, loc_d;
  logic [63:0]  val_q, val_d;
  logic [127:0] s0_q, s0_d, s1_q, s1_d;
  logic         t0_q, t0_d, t1_q, t1_d;
  logic [255:0] da_q, da_d;
  logic         sha_start;
  logic         sha_done;
  logic [255:0] dig;
  logic [127:0] msg;
  dpf_out_t     ow;
  logic [5:0]   lev_n;
  logic         bit_c, tcl, tcr, tk;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_q <= DomainBitsReset;
    end else if (cfg_we_i) begin
      dom_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (dom_q == '0) lev_n = 6'd1;
    else if (dom_q > 6'(MaxLevels)) lev_n = 6'(MaxLevels);
    else lev_n = dom_q;
  end

  // party zero seed is taken as it is being loaded, party one seed from its register
  assign msg = (st_q == StHash1 || (st_q == StHash0 && sha_done)) ? s1_q : s0_d;

  dpfkg_sha_core u_sha (
    .clk_i, .rst_ni, .start_i(sha_start), .msg_i(msg),
    .done_o(sha_done), .digest_o(dig)
  );

  // correction word from both digests (a in da_q, b in dig)
  always_comb begin
    bit_c = loc_q[5'(lev_q - 6'd1 - {1'b0, idx_q})];
    tcl = da_q[8] ^ dig[8] ^ ~bit_c;
    tcr = da_q[0] ^ dig[0] ^ bit_c;
    tk  = bit_c ? tcr : tcl;
    ow.level_index = idx_q;
    ow.left_seed_corr_hi  = bit_c ? da_q[255:192] ^ dig[255:192] : '0;
    ow.left_seed_corr_lo  = bit_c ? da_q[191:128] ^ dig[191:128] : '0;
    ow.right_seed_corr_hi = bit_c ? '0 : da_q[127:64] ^ dig[127:64];
    ow.right_seed_corr_lo = bit_c ? '0 : da_q[63:0] ^ dig[63:0];
    ow.left_flag_corr  = tcl;
    ow.right_flag_corr = tcr;
    ow.last_level = ({1'b0, idx_q} + 6'd1 == lev_q);
    ow.final_correction = ow.last_level ?
      (val_q ^ (bit_c ? da_q[63:0] ^ dig[63:0] : da_q[191:128] ^ dig[191:128])) : '0;
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (in_valid_i) st_d = StHash0;
      StHash0: if (sha_done) st_d = StHash1;
      StHash1: if (sha_done) st_d = StEmit;
      StEmit:  if (out_ready_i) st_d = ow.last_level ? StIdle : StHash0;
      default: st_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o  = (st_q == StIdle);
    out_valid_o = (st_q == StEmit);
    sha_start = 1'b0;
    lev_d = lev_q; idx_d = idx_q; loc_d = loc_q; val_d = val_q;
    s0_d = s0_q; s1_d = s1_q; t0_d = t0_q; t1_d = t1_q; da_d = da_q;
    unique case (st_q)
      StIdle: if (in_valid_i) begin
        sha_start = 1'b1;
        lev_d = lev_n; idx_d = '0;
        loc_d = in_data_i.location; val_d = in_data_i.point_value;
        s0_d = {in_data_i.party0_seed_hi, in_data_i.party0_seed_lo};
        s1_d = {in_data_i.party1_seed_hi, in_data_i.party1_seed_lo};
        t0_d = 1'b1; t1_d = 1'b0;
      end
      StHash0: if (sha_done) begin
        da_d = dig;
        sha_start = 1'b1;
      end
      StEmit: if (out_ready_i) begin
        s0_d = bit_c ? da_q[127:0] : da_q[255:128];
        s1_d = bit_c ? dig[127:0] : dig[255:128];
        t0_d = (bit_c ? da_q[0] : da_q[8]) ^ (t0_q & tk);
        t1_d = (bit_c ? dig[0] : dig[8]) ^ (t1_q & tk);
        idx_d = idx_q + 5'd1;
        sha_start = !ow.last_level;
      end
      default: ;
    endcase
  end

  assign out_data_o = ow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      lev_q <= 6'd1;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      lev_q <= lev_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    loc_q <= loc_d; val_q <= val_d; s0_q <= s0_d; s1_q <= s1_d;
    t0_q <= t0_d; t1_q <= t1_d; da_q <= da_d;
  end

`include "dpf_key_generation_assert.svh"
  `DPF_ASSERT(a_one_side, !(in_ready_o && out_valid_o), "ready during output")
  `DPF_ASSERT(a_idx_range, ({1'b0, idx_q} < lev_q) || st_q == StIdle, "level overrun")
  `DPF_ASSERT_NEXT(a_last_idle, out_valid_o && out_ready_i && out_data_o.last_level,
    in_ready_o, "not idle after last beat")
endmodule

// ----- sim/tb_dpf_key_generation.sv -----
`timescale 1ns / 1ps
module tb_dpf_key_generation;
  import dpfkg_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  localparam logic [31:0] RoundK [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [255:0] HashIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  dpf_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  dpf_out_t   out_data_o;

  dpf_in_t    pending_keys[$];
  dpf_out_t   expected_words[$];
  logic [5:0] depth_q;
  int         fail_count;
  int         cycle_count;
  int         in_gap;
  int         out_gap;
  logic       in_calm;
  logic       out_calm;

  dpf_key_generation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotr32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // sha-256 of a 16-byte seed, one padded block
  function automatic logic [255:0] seed_digest(logic [127:0] seed);
    logic [31:0] w [0:63];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    logic [255:0] iv;
    iv = HashIv;
    for (int i = 0; i < 16; i++) w[i] = 32'h0;
    w[0] = seed[127:96];
    w[1] = seed[95:64];
    w[2] = seed[63:32];
    w[3] = seed[31:0];
    w[4] = 32'h80000000;
    w[15] = 32'd128;
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = iv;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[i] + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {iv[255:224] + a, iv[223:192] + b, iv[191:160] + c, iv[159:128] + d,
            iv[127:96] + e, iv[95:64] + f, iv[63:32] + g, iv[31:0] + h};
  endfunction

  // walk the tree along the location path and queue one correction word per level
  task automatic queue_correction_words(dpf_in_t key);
    logic [127:0] seed0, seed1;
    logic [255:0] dig0, dig1;
    logic         flag0, flag1, steer_bit, keep;
    int           levels;
    dpf_out_t     word;
    seed0 = {key.party0_seed_hi, key.party0_seed_lo};
    seed1 = {key.party1_seed_hi, key.party1_seed_lo};
    flag0 = 1'b1;
    flag1 = 1'b0;
    levels = (depth_q == 0) ? 1 : (depth_q > MaxLevels) ? MaxLevels : depth_q;
    for (int i = 0; i < levels; i++) begin
      steer_bit = key.location[levels - 1 - i];
      dig0 = seed_digest(seed0);
      dig1 = seed_digest(seed1);
      word = '0;
      word.level_index = i[4:0];
      word.left_flag_corr = dig0[8] ^ dig1[8];
      word.right_flag_corr = dig0[0] ^ dig1[0];
      if (steer_bit) begin
        word.right_flag_corr = ~word.right_flag_corr;
        word.left_seed_corr_hi = dig0[255:192] ^ dig1[255:192];
        word.left_seed_corr_lo = dig0[191:128] ^ dig1[191:128];
        keep = word.right_flag_corr;
        seed0 = dig0[127:0];
        seed1 = dig1[127:0];
        flag0 = dig0[0] ^ (flag0 & keep);
        flag1 = dig1[0] ^ (flag1 & keep);
      end else begin
        word.left_flag_corr = ~word.left_flag_corr;
        word.right_seed_corr_hi = dig0[127:64] ^ dig1[127:64];
        word.right_seed_corr_lo = dig0[63:0] ^ dig1[63:0];
        keep = word.left_flag_corr;
        seed0 = dig0[255:128];
        seed1 = dig1[255:128];
        flag0 = dig0[8] ^ (flag0 & keep);
        flag1 = dig1[8] ^ (flag1 & keep);
      end
      word.last_level = (i + 1 == levels);
      if (word.last_level) word.final_correction = key.point_value ^ seed0[63:0] ^ seed1[63:0];
      expected_words = {expected_words, word};
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic dpf_in_t random_key();
    dpf_in_t k;
    k.location = $urandom;
    k.point_value = rand64();
    k.party0_seed_hi = rand64();
    k.party0_seed_lo = rand64();
    k.party1_seed_hi = rand64();
    k.party1_seed_lo = rand64();
    return k;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // input driver
  always @(posedge clk_i) begin
    logic    nxt_valid;
    dpf_in_t nxt_data;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      nxt_data = in_data_i;
      if (in_valid_i && in_ready_o) begin
        queue_correction_words(in_data_i);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_keys.size() != 0) begin
          nxt_data = pending_keys.pop_front();
          nxt_valid = 1'b1;
          if ($urandom_range(0, 31) == 0) in_calm <= ~in_calm;
          in_gap <= in_calm ? 0 : pick_gap();
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i <= nxt_data;
    end
  end

  // output monitor and backpressure
  always @(posedge clk_i) begin
    dpf_out_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected beat actual %h", $time, out_data_o);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("level_index", 64'(exp_w.level_index), 64'(out_data_o.level_index));
          check_field("left_seed_corr_hi", exp_w.left_seed_corr_hi,
                      out_data_o.left_seed_corr_hi);
          check_field("left_seed_corr_lo", exp_w.left_seed_corr_lo,
                      out_data_o.left_seed_corr_lo);
          check_field("right_seed_corr_hi", exp_w.right_seed_corr_hi,
                      out_data_o.right_seed_corr_hi);
          check_field("right_seed_corr_lo", exp_w.right_seed_corr_lo,
                      out_data_o.right_seed_corr_lo);
          check_field("left_flag_corr", 64'(exp_w.left_flag_corr),
                      64'(out_data_o.left_flag_corr));
          check_field("right_flag_corr", 64'(exp_w.right_flag_corr),
                      64'(out_data_o.right_flag_corr));
          check_field("final_correction", exp_w.final_correction,
                      out_data_o.final_correction);
          check_field("last_level", 64'(exp_w.last_level), 64'(out_data_o.last_level));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) out_calm <= ~out_calm;
        out_gap <= out_calm ? 0 : pick_gap();
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("dpf_key_generation: mismatch");
      $finish;
    end
  end

  task automatic write_depth(logic [5:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    depth_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sampled at the falling edge so that all driver updates have settled
  task automatic drain();
    @(negedge clk_i);
    while (pending_keys.size() != 0 || expected_words.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic queue_key(dpf_in_t key);
    pending_keys = {pending_keys, key};
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) queue_key(random_key());
  endtask

  // stimulus sequence
  initial begin
    dpf_in_t k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    in_gap = 0;
    out_gap = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    depth_q = DomainBitsReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset depth: all-zero and all-one fields, unused location bits set
    k = '0;
    queue_key(k);
    k = '1;
    queue_key(k);
    k = '0;
    k.location = 32'hfff00000;
    k.point_value = '1;
    queue_key(k);
    k = '1;
    k.location = 32'h000fffff;
    k.party1_seed_hi = '0;
    k.party1_seed_lo = '0;
    queue_key(k);
    k = random_key();
    k.party1_seed_hi = k.party0_seed_hi;
    k.party1_seed_lo = k.party0_seed_lo;
    queue_key(k);
    k = random_key();
    k.location = 32'h000aaaaa;
    queue_key(k);
    k = random_key();
    k.location = 32'h00055555;
    queue_key(k);
    drain();

    // single level, then zero levels treated as one
    write_depth(6'd1);
    queue_random(20);
    drain();
    write_depth(6'd0);
    queue_random(10);
    drain();

    // full depth, then saturation above the maximum
    write_depth(6'd32);
    k = '1;
    queue_key(k);
    k = '0;
    queue_key(k);
    queue_random(2);
    drain();
    write_depth(6'd63);
    queue_random(2);
    drain();
    write_depth(6'd33);
    queue_random(1);
    drain();

    // bulk random at small depths
    write_depth(6'd3);
    queue_random(40);
    drain();
    write_depth(6'd7);
    queue_random(30);
    drain();
    write_depth(6'd2);
    queue_random(30);
    drain();

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dpf_key_generation: match");
    end else begin
      $display("dpf_key_generation: mismatch");
    end
    $finish;
  end

endmodule
